FILE: hdl/cobs_crc32c_frame_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// cobs crc32c frame decoder: assertion macros
// shared check macros for the decoder modules; clocked on clk, CCFD_ASSERT off in reset
// ----------------------------------------------------------------------------
`ifndef COBS_CRC32C_FRAME_DECODER_UNIT_DEFINES_SVH
`define COBS_CRC32C_FRAME_DECODER_UNIT_DEFINES_SVH

// check held on every edge out of reset
`define CCFD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that also holds while reset is asserted
`define CCFD_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: hdl/ccfd_pkg.sv
// ----------------------------------------------------------------------------
// ccfd_pkg
// types, constants and the crc-32c byte step shared by the decoder modules
// ----------------------------------------------------------------------------
package ccfd_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int LEN_BYTES       = 2;
	localparam int CRC_BYTES       = 4;
	localparam int FRAME_OVERHEAD  = LEN_BYTES + CRC_BYTES;
	localparam int STORE_CAP       = MAX_FRAME_BYTES + FRAME_OVERHEAD;
	localparam int ADDR_W          = $clog2(STORE_CAP);
	localparam int COUNT_W         = $clog2(STORE_CAP + 1);

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [BYTE_W-1:0]  DELIM_BYTE  = 8'h00;
	localparam logic [BYTE_W-1:0]  FULL_CODE   = 8'hFF;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_COBS         = 3'd1,
		ST_SHORT        = 3'd2,
		ST_BAD_LEN      = 3'd3,
		ST_LEN_MISMATCH = 3'd4,
		ST_CRC          = 3'd5,
		ST_OVER_LIMIT   = 3'd6
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clear;
		logic load_err;
		logic rd;
		logic load_out;
	} ccfd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic    delim;
		logic    frame_started;
		logic    out_free;
		logic    is_last;
		status_t frame_status;
	} ccfd_stat_t;

	// reflected crc-32c, one byte
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
		input logic [BYTE_W-1:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: hdl/ccfd_stream_if.sv
// ----------------------------------------------------------------------------
// ccfd stream interfaces
// valid/ready channels for wire bytes in and decoded results out
// ----------------------------------------------------------------------------
interface ccfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;

	modport source (output valid, output wire_byte, input ready);
	modport sink   (input valid, input wire_byte, output ready);
endinterface

interface ccfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_of_frame;
	logic [2:0] frame_status;

	modport source (output valid, output payload_byte, output last_of_frame,
		output frame_status, input ready);
	modport sink   (input valid, input payload_byte, input last_of_frame,
		input frame_status, output ready);
endinterface

FILE: hdl/cobs_crc32c_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// cobs_crc32c_frame_decoder_unit
// cobs frame decoder with length and crc-32c check, payload or error out
// ----------------------------------------------------------------------------
// a nonzero wire byte is taken while idle and ready stays high after it;
// a delimiter that ends a frame moves to the check state, which waits for a free
// output register: an error item is loaded from there, each payload byte is a
// store read then an output load; wire input is held off until the frame drains
// reset: async, clears frame state and out valid, output_limit back to 64;
// decoded store is not cleared, only entries written in this frame are read
// ----------------------------------------------------------------------------
module cobs_crc32c_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	ccfd_in_if.sink     wire_in,
	ccfd_out_if.source  frame_out,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);
	import ccfd_pkg::*;

	// command and status between the sequencer and the datapath
	ccfd_cmd_t  cmd;
	ccfd_stat_t stat;
	logic       in_ready;

	// sequencer: owns the input handshake and the drain order
	ccfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (wire_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign wire_in.ready = in_ready;

	// datapath: unstuffing, store, crc, checks and the output register
	ccfd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.wire_byte   (wire_in.wire_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame_out   (frame_out)
	);

endmodule

FILE: hdl/ccfd_ctrl.sv
// ----------------------------------------------------------------------------
// ccfd_ctrl
// sequencer: byte intake, frame check and payload drain
// ----------------------------------------------------------------------------
module ccfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ccfd_pkg::ccfd_stat_t stat,
	output ccfd_pkg::ccfd_cmd_t  cmd
);
	import ccfd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.delim) begin
						if (stat.frame_started) begin
							state_d = S_CHECK;
						end else begin
							cmd.clear = 1'b1;
						end
					end
				end
			end
			S_CHECK: begin
				if (stat.out_free) begin
					if (stat.frame_status != ST_OK) begin
						cmd.load_err = 1'b1;
						cmd.clear    = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.rd  = 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (stat.is_last) begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "cobs_crc32c_frame_decoder_unit_defines.svh"

	`CCFD_ASSERT(a_load_needs_room, (cmd.load_out || cmd.load_err) |-> stat.out_free, "result loaded into a busy output register")
	`CCFD_ASSERT(a_read_then_load, cmd.rd |=> (state_q == S_LOAD), "store read not followed by load")
	`CCFD_ASSERT(a_check_resolves, (state_q == S_CHECK && stat.out_free) |=> (state_q != S_CHECK), "check state did not resolve")
	`CCFD_ASSERT(a_error_clears, cmd.load_err |-> cmd.clear, "error result without frame clear")

endmodule

FILE: hdl/ccfd_dp.sv
// ----------------------------------------------------------------------------
// ccfd_dp
// cobs unstuffing, decoded byte store, running crc, frame checks, output reg
// ----------------------------------------------------------------------------
module ccfd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccfd_pkg::ccfd_cmd_t  cmd,
	output ccfd_pkg::ccfd_stat_t stat,
	input  logic [7:0]           wire_byte,
	input  logic                 cfg_wr_en,
	input  logic [6:0]           cfg_wr_data,
	ccfd_out_if.source           frame_out
);
	import ccfd_pkg::*;

	logic [BYTE_W-1:0]  mem [STORE_CAP];
	logic [BYTE_W-1:0]  rdata_q;

	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  blk_rem_q;
	logic               was_full_q;
	logic               started_q;
	logic               overflow_q;
	logic [31:0]        crc_q;
	logic [LEN_W-1:0]   len_q;
	logic [31:0]        tail_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;
	status_t            out_status_q;

	logic               is_delim;
	logic               want_push;
	logic               do_push;
	logic [BYTE_W-1:0]  push_byte;
	logic               crc_take;
	logic               out_free;
	logic               is_last;
	status_t            status_d;

	assign is_delim  = (wire_byte == DELIM_BYTE);
	// code byte pushes the pending zero, data byte pushes itself
	assign want_push = cmd.accept && !is_delim && ((blk_rem_q != '0) || !was_full_q);
	assign push_byte = (blk_rem_q == '0) ? DELIM_BYTE : wire_byte;
	assign do_push   = want_push && (count_q < COUNT_W'(STORE_CAP));
	assign crc_take  = (count_q < COUNT_W'(LEN_BYTES)) ||
		(17'(count_q) < ({1'b0, len_q} + 17'(LEN_BYTES)));

	assign out_free = !out_valid_q || frame_out.ready;
	assign is_last  = (17'(ptr_q) == ({1'b0, len_q} + 17'd1));

	// checks in priority order
	always_comb begin
		if ((blk_rem_q != '0) || overflow_q) begin
			status_d = ST_COBS;
		end else if (count_q < COUNT_W'(FRAME_OVERHEAD)) begin
			status_d = ST_SHORT;
		end else if ((len_q == '0) || (len_q > LEN_W'(MAX_FRAME_BYTES))) begin
			status_d = ST_BAD_LEN;
		end else if (17'(count_q) != ({1'b0, len_q} + 17'(FRAME_OVERHEAD))) begin
			status_d = ST_LEN_MISMATCH;
		end else if ((crc_q ^ CRC_XOUT) != tail_q) begin
			status_d = ST_CRC;
		end else if (len_q > {{(LEN_W-LIMIT_W){1'b0}}, limit_q}) begin
			status_d = ST_OVER_LIMIT;
		end else begin
			status_d = ST_OK;
		end
	end

	assign stat.delim         = is_delim;
	assign stat.frame_started = started_q;
	assign stat.out_free      = out_free;
	assign stat.is_last       = is_last;
	assign stat.frame_status  = status_d;

	// decoded store
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[count_q[ADDR_W-1:0]] <= push_byte;
		end
		if (cmd.rd) begin
			rdata_q <= mem[ptr_q];
		end
	end

	// frame payload registers: length bytes and last four bytes
	always_ff @(posedge clk) begin
		if (do_push) begin
			tail_q <= {tail_q[23:0], push_byte};
			if (count_q == COUNT_W'(0)) begin
				len_q[15:8] <= push_byte;
			end
			if (count_q == COUNT_W'(1)) begin
				len_q[7:0] <= push_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			blk_rem_q  <= '0;
			was_full_q <= 1'b1;
			started_q  <= 1'b0;
			overflow_q <= 1'b0;
			crc_q      <= CRC_INIT;
			ptr_q      <= ADDR_W'(LEN_BYTES);
			limit_q    <= LIMIT_RESET;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				count_q    <= '0;
				blk_rem_q  <= '0;
				was_full_q <= 1'b1;
				started_q  <= 1'b0;
				overflow_q <= 1'b0;
				crc_q      <= CRC_INIT;
				ptr_q      <= ADDR_W'(LEN_BYTES);
			end else begin
				if (cmd.accept && !is_delim) begin
					started_q <= 1'b1;
					if (blk_rem_q == '0) begin
						blk_rem_q  <= wire_byte - 8'd1;
						was_full_q <= (wire_byte == FULL_CODE);
					end else begin
						blk_rem_q <= blk_rem_q - 8'd1;
					end
				end
				if (want_push) begin
					if (do_push) begin
						count_q <= count_q + COUNT_W'(1);
						if (crc_take) begin
							crc_q <= crc32c_byte(crc_q, push_byte);
						end
					end else begin
						overflow_q <= 1'b1;
					end
				end
				if (cmd.load_out) begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			out_byte_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= status_d;
		end else if (cmd.load_out) begin
			out_byte_q   <= rdata_q;
			out_last_q   <= is_last;
			out_status_q <= ST_OK;
		end
	end

	assign frame_out.valid         = out_valid_q;
	assign frame_out.payload_byte  = out_byte_q;
	assign frame_out.last_of_frame = out_last_q;
	assign frame_out.frame_status  = out_status_q;

	`include "cobs_crc32c_frame_decoder_unit_defines.svh"

	`CCFD_ASSERT_ALWAYS(a_count_in_range, count_q <= COUNT_W'(STORE_CAP), "decoded count beyond store size")
	`CCFD_ASSERT(a_overflow_only_full, overflow_q |-> (count_q == COUNT_W'(STORE_CAP)), "overflow flagged with room left")
	`CCFD_ASSERT(a_error_item_shape, (out_valid_q && out_status_q != ST_OK) |-> (out_last_q && out_byte_q == '0), "error result not marked last or not zero")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// cobs frame decoder check: frames are built and encoded here, sent byte by
// byte, and every decoded payload byte or error item is compared in order
// against an in-bench decoder that tracks the same frame state
// ----------------------------------------------------------------------------
module testbench;
	import ccfd_pkg::*;

	typedef logic [7:0] octet_q_t[$];

	// one item on the result channel
	typedef struct packed {
		logic [7:0] payload;
		logic       last;
		status_t    status;
	} frame_result_t;

	localparam logic [31:0] CASTAGNOLI_POLY_REFL = 32'h82F6_3B78;
	localparam int          SETTLE_CYCLES        = 8;
	localparam int          REPORT_LIMIT         = 10;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;

	ccfd_in_if  wire_bus ();
	ccfd_out_if result_bus ();

	cobs_crc32c_frame_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wire_in     (wire_bus),
		.frame_out   (result_bus),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// decoder state mirrored in the bench, same reset values as the block
	logic [7:0] mir_store [STORE_CAP];
	int         mir_count     = 0;
	int         mir_remaining = 0;
	bit         mir_was_full  = 1'b1;
	bit         mir_started   = 1'b0;
	bit         mir_overflow  = 1'b0;
	int         mir_limit     = 64;

	// decoded items still to come out of the block, oldest first
	frame_result_t results_due[$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int wire_bytes_sent    = 0;
	int frames_sent        = 0;
	int results_checked    = 0;
	int failures           = 0;

	// 50 MHz
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// crc-32c, reflected, init and final xor all ones, bit at a time
	// ------------------------------------------------------------------------
	function automatic logic [31:0] crc32c_of(input octet_q_t data);
		logic [31:0] crc;
		crc = 32'hFFFF_FFFF;
		foreach (data[i]) begin
			crc ^= {24'd0, data[i]};
			for (int k = 0; k < 8; k++) begin
				crc = crc[0] ? ((crc >> 1) ^ CASTAGNOLI_POLY_REFL) : (crc >> 1);
			end
		end
		return crc ^ 32'hFFFF_FFFF;
	endfunction

	// ------------------------------------------------------------------------
	// mirrored decoder
	// ------------------------------------------------------------------------
	function automatic void clear_frame_state();
		mir_count     = 0;
		mir_remaining = 0;
		mir_was_full  = 1'b1;
		mir_started   = 1'b0;
		mir_overflow  = 1'b0;
	endfunction

	// append past the store end is dropped and flags overflow
	function automatic void store_append(input logic [7:0] b);
		if (mir_count < STORE_CAP) begin
			mir_store[mir_count] = b;
			mir_count++;
		end else begin
			mir_overflow = 1'b1;
		end
	endfunction

	// delimiter checks in priority order, first failing one wins
	function automatic status_t frame_verdict(output int len);
		logic [31:0] sent_crc;
		octet_q_t    covered;
		len = 0;
		if (mir_remaining != 0 || mir_overflow) return ST_COBS;
		if (mir_count < FRAME_OVERHEAD) return ST_SHORT;
		len = {mir_store[0], mir_store[1]};
		if (len == 0 || len > MAX_FRAME_BYTES) return ST_BAD_LEN;
		if (mir_count != len + FRAME_OVERHEAD) return ST_LEN_MISMATCH;
		sent_crc = {mir_store[len + 2], mir_store[len + 3], mir_store[len + 4],
			mir_store[len + 5]};
		for (int i = 0; i < len + LEN_BYTES; i++) covered.push_back(mir_store[i]);
		if (crc32c_of(covered) != sent_crc) return ST_CRC;
		if (len > mir_limit) return ST_OVER_LIMIT;
		return ST_OK;
	endfunction

	// one accepted wire byte; queues whatever items the block owes for it
	function automatic void decode_wire_byte(input logic [7:0] b);
		status_t verdict;
		int      len;
		if (b != DELIM_BYTE) begin
			mir_started = 1'b1;
			if (mir_remaining == 0) begin
				// code byte: a short previous block implies a zero
				if (!mir_was_full) store_append(8'h00);
				mir_remaining = int'(b) - 1;
				mir_was_full  = (b == FULL_CODE);
			end else begin
				store_append(b);
				mir_remaining--;
			end
		end else if (mir_started) begin
			verdict = frame_verdict(len);
			if (verdict != ST_OK) begin
				results_due.push_back('{payload: 8'h00, last: 1'b1, status: verdict});
			end else begin
				for (int i = 0; i < len; i++) begin
					results_due.push_back('{payload: mir_store[i + LEN_BYTES],
						last: (i == len - 1), status: ST_OK});
				end
			end
			clear_frame_state();
		end else begin
			// empty delimiter: nothing out
			clear_frame_state();
		end
	endfunction

	// ------------------------------------------------------------------------
	// frame building
	// ------------------------------------------------------------------------
	function automatic void append_block(ref octet_q_t enc, ref octet_q_t blk,
		input logic [7:0] code);
		enc.push_back(code);
		foreach (blk[j]) enc.push_back(blk[j]);
		blk.delete();
	endfunction

	// standard cobs, no implied zero after the final block
	function automatic octet_q_t stuff_frame(input octet_q_t raw);
		octet_q_t enc;
		octet_q_t blk;
		foreach (raw[i]) begin
			if (raw[i] == 8'h00) begin
				append_block(enc, blk, 8'(blk.size() + 1));
			end else begin
				blk.push_back(raw[i]);
				if (blk.size() == 254) append_block(enc, blk, FULL_CODE);
			end
		end
		append_block(enc, blk, 8'(blk.size() + 1));
		return enc;
	endfunction

	// length field, payload, crc; optionally one crc bit flipped
	function automatic octet_q_t frame_bytes(input logic [15:0] len_field,
		input octet_q_t body, input bit corrupt_crc);
		octet_q_t    raw;
		logic [31:0] crc;
		raw.push_back(len_field[15:8]);
		raw.push_back(len_field[7:0]);
		foreach (body[i]) raw.push_back(body[i]);
		crc = crc32c_of(raw);
		if (corrupt_crc) crc ^= 32'h1 << $urandom_range(31);
		raw.push_back(crc[31:24]);
		raw.push_back(crc[23:16]);
		raw.push_back(crc[15:8]);
		raw.push_back(crc[7:0]);
		return raw;
	endfunction

	// zero-heavy so that cobs blocks come out short and varied
	function automatic octet_q_t random_payload(input int n);
		octet_q_t q;
		for (int i = 0; i < n; i++) begin
			q.push_back(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(255)));
		end
		return q;
	endfunction

	function automatic octet_q_t good_frame(input int n);
		return frame_bytes(16'(n), random_payload(n), 1'b0);
	endfunction

	// mostly short payloads, a few up to the maximum
	function automatic int random_length();
		int r;
		r = $urandom_range(99);
		if (r < 85) return $urandom_range(1, 8);
		if (r < 95) return $urandom_range(9, 32);
		return $urandom_range(33, MAX_FRAME_BYTES);
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------
	// one wire item; valid stays up afterwards so back to back items run
	// without a bubble, whoever comes next lowers it if needed
	task automatic send_wire(input logic [7:0] b);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			wire_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		wire_bus.valid     <= 1'b1;
		wire_bus.wire_byte <= b;
		@(posedge clk);
		while (!wire_bus.ready) @(posedge clk);
		decode_wire_byte(b);
		wire_bytes_sent++;
	endtask

	// encoded bytes then the delimiter
	task automatic send_encoded(input octet_q_t enc);
		foreach (enc[i]) send_wire(enc[i]);
		send_wire(DELIM_BYTE);
		frames_sent++;
	endtask

	task automatic send_frame(input octet_q_t raw);
		send_encoded(stuff_frame(raw));
	endtask

	// block idle: nothing owed, then time for a frame that owes nothing
	task automatic settle_idle();
		wire_bus.valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_output_limit(input logic [6:0] value);
		settle_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mir_limit = value;
	endtask

	// receiver stalls at random
	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT) $display("%s", msg);
	endtask

	// result checker: each accepted item against the oldest one owed
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.payload = result_bus.payload_byte;
			got.last    = result_bus.last_of_frame;
			got.status  = status_t'(result_bus.frame_status);
			if (results_due.size() == 0) begin
				note_failure($sformatf("unexpected item: data %02h last %0b status %0d",
					got.payload, got.last, got.status));
			end else begin
				want = results_due.pop_front();
				if (got.payload !== want.payload || got.last !== want.last ||
					got.status !== want.status) begin
					note_failure($sformatf({"item %0d: expected data %02h last %0b ",
						"status %0d, got data %02h last %0b status %0d"},
						results_checked, want.payload, want.last, want.status,
						got.payload, got.last, got.status));
				end
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// lone delimiters, a code byte with nothing behind it, a frame under six bytes
	task automatic test_empty_and_short();
		octet_q_t enc;
		octet_q_t raw;
		send_wire(DELIM_BYTE);
		send_wire(DELIM_BYTE);
		enc.push_back(8'h01);
		send_encoded(enc);
		raw.push_back(8'h00);
		raw.push_back(8'h05);
		raw.push_back(8'hAA);
		send_frame(raw);
	endtask

	// zero and all-ones payload bytes in one short frame
	task automatic test_payload_extremes();
		octet_q_t body;
		body.push_back(8'h00);
		body.push_back(8'hFF);
		send_frame(frame_bytes(16'd2, body, 1'b0));
	endtask

	// length field and crc faults
	task automatic test_header_faults();
		octet_q_t none;
		send_frame(frame_bytes(16'd0, none, 1'b0));
		send_frame(frame_bytes(16'hFFFF, random_payload(1), 1'b0));
		// length one above what follows
		send_frame(frame_bytes(16'd3, random_payload(2), 1'b0));
		send_frame(frame_bytes(16'd1, random_payload(1), 1'b1));
	endtask

	// truncated block and store overflow
	task automatic test_cobs_faults();
		octet_q_t enc;
		// full-size code with only a few data bytes
		enc.push_back(FULL_CODE);
		for (int i = 1; i <= 3; i++) enc.push_back(8'(i));
		send_encoded(enc);
		// well-formed encoding of a frame one byte past the store
		send_frame(frame_bytes(16'(MAX_FRAME_BYTES + 1),
			random_payload(MAX_FRAME_BYTES + 1), 1'b0));
	endtask

	// limit edges, including zero and the top of the 7-bit field
	task automatic test_output_limit();
		write_output_limit(7'd1);
		send_frame(good_frame(1));
		send_frame(good_frame(2));
		write_output_limit(7'd0);
		send_frame(good_frame(1));
		write_output_limit(7'd127);
		send_frame(good_frame(2));
		write_output_limit(LIMIT_RESET);
	endtask

	// one random frame: mostly well-formed, the rest faulty or noise
	task automatic random_frame_case();
		octet_q_t enc;
		int       r;
		int       n;
		int       code;
		r = $urandom_range(99);
		n = random_length();
		if (r < 60) begin
			send_frame(good_frame(n));
		end else if (r < 67) begin
			send_frame(frame_bytes(16'(n), random_payload(n), 1'b1));
		end else if (r < 73) begin
			// declared length off from the actual payload
			send_frame(frame_bytes(16'(n + $urandom_range(1, 3)), random_payload(n), 1'b0));
		end else if (r < 78) begin
			send_frame(frame_bytes(($urandom_range(1) == 0) ? 16'd0 :
				16'($urandom_range(MAX_FRAME_BYTES + 1, 16'hFFFF)), random_payload(n), 1'b0));
		end else if (r < 84) begin
			// block cut short before the delimiter
			enc  = stuff_frame(good_frame(n));
			code = $urandom_range(2, 12);
			enc.push_back(8'(code));
			repeat ($urandom_range(0, code - 2)) enc.push_back(8'($urandom_range(1, 255)));
			send_encoded(enc);
		end else if (r < 92) begin
			// line noise, zeros included
			repeat ($urandom_range(1, 12)) send_wire(8'($urandom_range(255)));
			send_wire(DELIM_BYTE);
		end else if (r < 96) begin
			send_frame(random_payload($urandom_range(1, FRAME_OVERHEAD - 1)));
		end else begin
			send_wire(DELIM_BYTE);
		end
	endtask

	// random traffic under one idle profile and one limit
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int byte_budget);
		int start;
		write_output_limit(7'($urandom_range(1, MAX_FRAME_BYTES)));
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		start = wire_bytes_sent;
		while (wire_bytes_sent - start < byte_budget) random_frame_case();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		wire_bus.valid      = 1'b0;
		wire_bus.wire_byte  = 8'h00;
		result_bus.ready    = 1'b1;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = LIMIT_RESET;
		clear_frame_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_short();
		test_payload_extremes();
		test_header_faults();
		test_cobs_faults();
		test_output_limit();
		test_random_traffic(0, 0, 8);
		test_random_traffic(52, 0, 8);
		test_random_traffic(0, 52, 8);
		test_random_traffic(23, 23, 8);

		// drain whatever the block still owes
		settle_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d frames in %0d wire bytes, %0d decoded items checked",
			frames_sent, wire_bytes_sent, results_checked);
		$display("every fault status, store overflow, limits 0, 1 and 127, four idle profiles");
		if (failures == 0 && results_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
